>>> src/rlts_pkg.sv
// package: shared types and constants for the link test statistics block
`default_nettype none
package rlts_pkg;
	localparam int MaxPayload = 32;
	localparam int PosW = $clog2(MaxPayload + 1);

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_END   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [1:0] REG_CHANNEL = 2'd0;
	localparam logic [1:0] REG_MARGIN  = 2'd1;
	localparam logic [1:0] REG_SEQLOW  = 2'd2;

	typedef enum logic [1:0] {
		EV_SHORT = 2'd0,
		EV_DROP  = 2'd1,
		EV_CRC   = 2'd2,
		EV_GOOD  = 2'd3
	} ev_kind_t;

	typedef struct packed {
		logic        clear;
		ev_kind_t    kind;
		logic [31:0] seq;
		logic [47:0] dev;
		logic [7:0]  batt;
		logic [6:0]  rssi;
	} event_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'd0, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> src/rlts_front.sv
// front end: byte capture, crc and packet classification
`default_nettype none
module rlts_front (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                op,
	input  wire logic [7:0]                data_byte,
	input  wire logic [6:0]                signal_strength,
	input  wire logic [7:0]                expected_channel,
	output logic                           ev_valid,
	input  wire logic                      ev_ready,
	output rlts_pkg::event_t               ev
);
	logic [rlts_pkg::PosW-1:0] pos_q;
	logic [15:0] crc_q, crcc_q;
	logic [7:0]  chan_q, batt_q;
	logic [31:0] seq_q;
	logic [47:0] dev_q;
	logic        acc, byte_acc;
	rlts_pkg::op_t op_e;

	assign op_e     = rlts_pkg::op_t'(op);
	assign in_ready = ev_ready;
	assign acc      = in_valid && in_ready;
	assign byte_acc = acc && op_e == rlts_pkg::OP_BYTE
		&& pos_q < rlts_pkg::PosW'(rlts_pkg::MaxPayload);
	assign ev_valid = in_valid && (op_e == rlts_pkg::OP_END || op_e == rlts_pkg::OP_CLEAR);

	always_comb begin
		ev       = '0;
		ev.clear = op_e == rlts_pkg::OP_CLEAR;
		ev.seq   = seq_q;
		ev.dev   = dev_q;
		ev.batt  = batt_q;
		ev.rssi  = signal_strength;
		if (pos_q < rlts_pkg::PosW'(16))
			ev.kind = rlts_pkg::EV_SHORT;
		else if (chan_q != expected_channel)
			ev.kind = rlts_pkg::EV_DROP;
		else if (crc_q != crcc_q)
			ev.kind = rlts_pkg::EV_CRC;
		else
			ev.kind = rlts_pkg::EV_GOOD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0; crc_q <= 16'hFFFF; crcc_q <= '0; chan_q <= '0;
			batt_q <= '0; seq_q <= '0; dev_q <= '0;
		end else if (acc && op_e == rlts_pkg::OP_END) begin
			pos_q <= '0; crc_q <= 16'hFFFF; crcc_q <= '0; chan_q <= '0;
			batt_q <= '0; seq_q <= '0; dev_q <= '0;
		end else if (byte_acc) begin
			pos_q <= pos_q + 1'b1;
			if (pos_q < rlts_pkg::PosW'(14))
				crc_q <= rlts_pkg::crc_byte(crc_q, data_byte);
			case (pos_q)
				rlts_pkg::PosW'(2):  chan_q <= data_byte;
				rlts_pkg::PosW'(3):  seq_q[7:0] <= data_byte;
				rlts_pkg::PosW'(4):  seq_q[15:8] <= data_byte;
				rlts_pkg::PosW'(5):  seq_q[23:16] <= data_byte;
				rlts_pkg::PosW'(6):  seq_q[31:24] <= data_byte;
				rlts_pkg::PosW'(7):  dev_q[7:0] <= data_byte;
				rlts_pkg::PosW'(8):  dev_q[15:8] <= data_byte;
				rlts_pkg::PosW'(9):  dev_q[23:16] <= data_byte;
				rlts_pkg::PosW'(10): dev_q[31:24] <= data_byte;
				rlts_pkg::PosW'(11): dev_q[39:32] <= data_byte;
				rlts_pkg::PosW'(12): dev_q[47:40] <= data_byte;
				rlts_pkg::PosW'(13): batt_q <= data_byte;
				rlts_pkg::PosW'(14): crcc_q[7:0] <= data_byte;
				rlts_pkg::PosW'(15): crcc_q[15:8] <= data_byte;
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_pos_max: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= rlts_pkg::PosW'(rlts_pkg::MaxPayload)) else $error("position overrun");
	a_end_rst: assert property (@(posedge clk) disable iff (!arst_n)
		acc && op_e == rlts_pkg::OP_END |=> pos_q == '0 && crc_q == 16'hFFFF)
		else $error("packet state not restarted");
	a_ev_kind: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && pos_q < rlts_pkg::PosW'(16) |-> ev.kind == rlts_pkg::EV_SHORT)
		else $error("short packet misclassified");
`endif
endmodule
`default_nettype wire

>>> src/rlts_fifo.sv
// two-entry event queue between front and back
`default_nettype none
module rlts_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire rlts_pkg::event_t wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output rlts_pkg::event_t      rd_data
);
	rlts_pkg::event_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

`ifndef ASSERT_OFF
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'd2)
		else $error("queue count overflow");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer mismatch");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && !rd_ready && !wr |=> $stable(cnt_q)) else $error("queue lost entry");
`endif
endmodule
`default_nettype wire

>>> src/rlts_back.sv
// back end: statistics update and result register
`default_nettype none
module rlts_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             ev_valid,
	output logic                  ev_ready,
	input  wire rlts_pkg::event_t ev,
	input  wire logic [31:0]      advance_margin,
	input  wire logic [31:0]      seq_low_start,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [31:0] packets_count, output logic [7:0] short_count,
	output logic [31:0] crc_error_count, output logic [31:0] largest_gap,
	output logic [6:0] strength_low, output logic [6:0] strength_high,
	output logic [31:0] strength_total, output logic [31:0] sequence_low,
	output logic [31:0] sequence_high, output logic advance_ready,
	output logic [6:0] battery_low, output logic [47:0] device_id
);
	logic [31:0] pkt_q, crce_q, gap_q, sum_q, slo_q, shi_q, prev_q;
	logic [7:0]  short_q;
	logic [6:0]  rlo_q, rhi_q, blo_q;
	logic        adv_q, ovalid_q, take;
	logic [47:0] dev_q;
	logic [31:0] gap;

	assign ev_ready  = !ovalid_q || out_ready;
	assign take      = ev_valid && ev_ready;
	assign out_valid = ovalid_q;
	assign gap       = ev.seq - prev_q - 32'd1;

	assign packets_count = pkt_q; assign short_count = short_q;
	assign crc_error_count = crce_q; assign largest_gap = gap_q;
	assign strength_low = rlo_q; assign strength_high = rhi_q;
	assign strength_total = sum_q; assign sequence_low = slo_q;
	assign sequence_high = shi_q; assign advance_ready = adv_q;
	assign battery_low = blo_q; assign device_id = dev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0; pkt_q <= '0; short_q <= '0; crce_q <= '0; gap_q <= '0;
			rlo_q <= 7'd127; rhi_q <= '0; sum_q <= '0; slo_q <= 32'd10000; shi_q <= '0;
			adv_q <= 1'b0; blo_q <= 7'd127; prev_q <= '0; dev_q <= '0;
		end else begin
			ovalid_q <= take || (ovalid_q && !out_ready);
			if (take) begin
				if (ev.clear) begin
					pkt_q <= '0; short_q <= '0; crce_q <= '0; gap_q <= '0;
					rlo_q <= 7'd127; rhi_q <= '0; sum_q <= '0; slo_q <= seq_low_start;
					shi_q <= '0; adv_q <= 1'b0; blo_q <= 7'd127;
				end else begin
					case (ev.kind)
						rlts_pkg::EV_SHORT: short_q <= short_q + 8'd1;
						rlts_pkg::EV_CRC:   crce_q <= crce_q + 32'd1;
						rlts_pkg::EV_GOOD: begin
							if (ev.batt[7] && ev.batt[6:0] < blo_q) blo_q <= ev.batt[6:0];
							dev_q <= ev.dev;
							if (ev.seq > prev_q && gap > gap_q) gap_q <= gap;
							prev_q <= ev.seq;
							pkt_q <= pkt_q + 32'd1;
							if (ev.rssi > rhi_q) rhi_q <= ev.rssi;
							if (ev.rssi < rlo_q) rlo_q <= ev.rssi;
							if (ev.seq > shi_q) shi_q <= ev.seq;
							if (ev.seq < slo_q) slo_q <= ev.seq;
							sum_q <= sum_q + {25'd0, ev.rssi};
							if (ev.seq > advance_margin) adv_q <= 1'b1;
						end
						default: ;
					endcase
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_load: assert property (@(posedge clk) disable iff (!arst_n) take |=> ovalid_q)
		else $error("result not presented");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ready |=> $stable(pkt_q) && $stable(short_q))
		else $error("stats changed under stall");
	a_range: assert property (@(posedge clk) disable iff (!arst_n) rlo_q <= 7'd127 && blo_q <= 7'd127)
		else $error("bad low value");
`endif
endmodule
`default_nettype wire

>>> src/radio_link_test_statistics.sv
// top level: radio link test statistics
// a packet end or clear item reaches its result through the queue, then the result register
// throughput: one item per cycle; items stall only while the queue is full
// the queue holds two events, the back end one result register
// reset: asynchronous, clears packet capture and statistics, registers to 0, 9000, 10000
`default_nettype none
module radio_link_test_statistics (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [23:0]   s_tdata,   // op[1:0], data_byte[9:2], signal_strength[16:10]
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [271:0]       m_tdata,   // packets..device_id from bit 0 up, zero filled
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);
	logic [7:0]  chan_q;
	logic [31:0] margin_q, slo_q;
	logic        fe_valid, fe_ready, q_valid, q_ready;
	rlts_pkg::event_t fe_ev, q_ev;
	logic [31:0] pc, ce, lg, st, sl, sh;
	logic [7:0]  sc;
	logic [6:0]  rl, rh, bl;
	logic        ar;
	logic [47:0] di;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0; margin_q <= 32'd9000; slo_q <= 32'd10000;
		end else if (cfg_we) begin
			case (cfg_index)
				rlts_pkg::REG_CHANNEL: chan_q <= cfg_data[7:0];
				rlts_pkg::REG_MARGIN:  margin_q <= cfg_data;
				rlts_pkg::REG_SEQLOW:  slo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rlts_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.op(s_tdata[1:0]), .data_byte(s_tdata[9:2]), .signal_strength(s_tdata[16:10]),
		.expected_channel(chan_q), .ev_valid(fe_valid), .ev_ready(fe_ready), .ev(fe_ev));

	rlts_fifo u_fifo (.clk, .arst_n, .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_data(fe_ev),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_ev));

	rlts_back u_back (.clk, .arst_n, .ev_valid(q_valid), .ev_ready(q_ready), .ev(q_ev),
		.advance_margin(margin_q), .seq_low_start(slo_q), .out_valid(m_tvalid),
		.out_ready(m_tready), .packets_count(pc), .short_count(sc), .crc_error_count(ce),
		.largest_gap(lg), .strength_low(rl), .strength_high(rh), .strength_total(st),
		.sequence_low(sl), .sequence_high(sh), .advance_ready(ar), .battery_low(bl),
		.device_id(di));

	assign m_tdata = {2'd0, di, bl, ar, sh, sl, st, rh, rl, lg, ce, sc, pc};
endmodule
`default_nettype wire

>>> bench/tb_top.sv
// testbench for the radio link test statistics block: directed and random packets, scoreboard, stalls
`timescale 1ns / 1ps
module tb_top;
	typedef struct packed {
		logic [47:0] device_id;
		logic [6:0]  battery_low;
		logic        advance_ready;
		logic [31:0] sequence_high;
		logic [31:0] sequence_low;
		logic [31:0] strength_total;
		logic [6:0]  strength_high;
		logic [6:0]  strength_low;
		logic [31:0] largest_gap;
		logic [31:0] crc_error_count;
		logic [7:0]  short_count;
		logic [31:0] packets_count;
	} link_stats_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [271:0] m_tdata;
	logic cfg_we = 0;
	logic [1:0] cfg_index = rlts_pkg::REG_CHANNEL;
	logic [31:0] cfg_data = '0;

	radio_link_test_statistics uut (.*);

	// model state
	logic [7:0]  want_chan;
	logic [31:0] margin, low_start;
	int          pos;
	logic [15:0] crc_run, crc_got;
	logic [7:0]  chan_got, batt_got;
	logic [31:0] seq_got, prev_seq;
	logic [47:0] dev_got, prev_dev;
	link_stats_t stats;

	link_stats_t stats_due[$];
	logic [23:0] pending[$];
	logic [7:0]  pkt[64];
	int          fails = 0;
	int          burst = 0, gap = 0, stall = 0;
	logic [31:0] last_seq = 0;

	initial forever #1 clk = ~clk;

	initial begin
		#2000000;
		$display("radio_link_test_statistics: mismatch");
		$finish;
	end

	function automatic logic [15:0] modbus_step(logic [15:0] c, logic [7:0] b);
		c = c ^ {8'd0, b};
		for (int i = 0; i < 8; i++)
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		return c;
	endfunction

	task automatic clear_stats();
		stats = '0;
		stats.strength_low = 7'd127;
		stats.battery_low = 7'd127;
		stats.sequence_low = low_start;
	endtask

	task automatic new_packet();
		pos = 0;
		crc_run = 16'hFFFF;
		chan_got = 8'd0;
		seq_got = 32'd0;
		dev_got = 48'd0;
		batt_got = 8'd0;
		crc_got = 16'd0;
	endtask

	task automatic predict(logic [23:0] w);
		logic [1:0]  op;
		logic [7:0]  b;
		logic [6:0]  rssi;
		logic [31:0] g;
		op = w[1:0];
		b = w[9:2];
		rssi = w[16:10];
		case (op)
			rlts_pkg::OP_BYTE: begin
				if (pos < rlts_pkg::MaxPayload) begin
					if (pos < 14) crc_run = modbus_step(crc_run, b);
					if (pos == 2) chan_got = b;
					else if (pos >= 3 && pos <= 6) seq_got[8*(pos-3) +: 8] = b;
					else if (pos >= 7 && pos <= 12) dev_got[8*(pos-7) +: 8] = b;
					else if (pos == 13) batt_got = b;
					else if (pos == 14 || pos == 15) crc_got[8*(pos-14) +: 8] = b;
					pos++;
				end
			end
			rlts_pkg::OP_END: begin
				if (pos < 16) stats.short_count++;
				else if (chan_got != want_chan) ;
				else if (crc_run != crc_got) stats.crc_error_count++;
				else begin
					if (batt_got[7] && batt_got[6:0] < stats.battery_low)
						stats.battery_low = batt_got[6:0];
					prev_dev = dev_got;
					if (seq_got > prev_seq) begin
						g = seq_got - prev_seq - 32'd1;
						if (g > stats.largest_gap) stats.largest_gap = g;
					end
					prev_seq = seq_got;
					stats.packets_count++;
					if (rssi > stats.strength_high) stats.strength_high = rssi;
					if (rssi < stats.strength_low) stats.strength_low = rssi;
					if (seq_got > stats.sequence_high) stats.sequence_high = seq_got;
					if (seq_got < stats.sequence_low) stats.sequence_low = seq_got;
					stats.strength_total += {25'd0, rssi};
					if (seq_got > margin) stats.advance_ready = 1'b1;
				end
				new_packet();
			end
			rlts_pkg::OP_CLEAR: clear_stats();
			default: ;
		endcase
		if (op == rlts_pkg::OP_END || op == rlts_pkg::OP_CLEAR) begin
			stats.device_id = prev_dev;
			stats_due.push_back(stats);
		end
	endtask

	function automatic logic [23:0] item(rlts_pkg::op_t op, logic [7:0] b, logic [6:0] rssi);
		return {7'd0, rssi, b, op};
	endfunction

	task automatic send_packet(int len, logic [7:0] chan, logic [31:0] seq,
			logic [47:0] dev, logic [7:0] batt, bit crc_ok, logic [6:0] rssi);
		logic [15:0] c;
		for (int i = 0; i < len; i++) pkt[i] = 8'($urandom);
		pkt[2] = chan;
		for (int i = 0; i < 4; i++) pkt[3+i] = seq[8*i +: 8];
		for (int i = 0; i < 6; i++) pkt[7+i] = dev[8*i +: 8];
		pkt[13] = batt;
		c = 16'hFFFF;
		for (int i = 0; i < 14; i++) c = modbus_step(c, pkt[i]);
		if (!crc_ok) c ^= 16'h1 << $urandom_range(15);
		pkt[14] = c[7:0];
		pkt[15] = c[15:8];
		for (int i = 0; i < len; i++)
			pending.push_back(item(rlts_pkg::OP_BYTE, pkt[i], 7'($urandom)));
		pending.push_back(item(rlts_pkg::OP_END, 8'($urandom), rssi));
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending.size() || s_tvalid || stats_due.size());
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			rlts_pkg::REG_CHANNEL: want_chan = val[7:0];
			rlts_pkg::REG_MARGIN: margin = val;
			default: low_start = val;
		endcase
	endtask

	task automatic random_packet();
		int len;
		logic [31:0] seq;
		case ($urandom_range(9))
			0: len = $urandom_range(15);
			1: len = $urandom_range(33, 40);
			default: len = $urandom_range(16, 32);
		endcase
		case ($urandom_range(7))
			0: seq = $urandom;
			1: seq = last_seq - $urandom_range(3);
			default: seq = last_seq + $urandom_range(1, 5);
		endcase
		last_seq = seq;
		send_packet(len, ($urandom_range(9) == 0) ? 8'($urandom) : want_chan, seq,
			48'({$urandom, $urandom}), 8'($urandom), $urandom_range(7) != 0,
			7'($urandom));
	endtask

	// sender: bursts with gaps, prediction on acceptance
	always @(posedge clk) begin
		if (s_tvalid && s_tready) predict(s_tdata);
		if (!s_tvalid || s_tready) begin
			if (gap > 0) begin
				gap--;
				s_tvalid <= 0;
			end else if (pending.size()) begin
				s_tdata <= pending.pop_front();
				s_tvalid <= 1;
				if (burst == 0) begin
					burst = $urandom_range(40);
					gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(6);
				end else burst--;
			end else s_tvalid <= 0;
		end
	end

	// receiver stall pattern and result check
	always @(posedge clk) begin
		link_stats_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(link_stats_t)-1:0];
			if (stats_due.size() == 0) begin
				$error("result with nothing expected");
				fails++;
			end else begin
				want = stats_due.pop_front();
				if (got.packets_count !== want.packets_count) begin
					$error("packets_count exp %0d got %0d", want.packets_count, got.packets_count);
					fails++;
				end
				if (got.short_count !== want.short_count) begin
					$error("short_count exp %0d got %0d", want.short_count, got.short_count);
					fails++;
				end
				if (got.crc_error_count !== want.crc_error_count) begin
					$error("crc_error_count exp %0d got %0d", want.crc_error_count,
						got.crc_error_count);
					fails++;
				end
				if (got.largest_gap !== want.largest_gap) begin
					$error("largest_gap exp %0d got %0d", want.largest_gap, got.largest_gap);
					fails++;
				end
				if (got.strength_low !== want.strength_low) begin
					$error("strength_low exp %0d got %0d", want.strength_low, got.strength_low);
					fails++;
				end
				if (got.strength_high !== want.strength_high) begin
					$error("strength_high exp %0d got %0d", want.strength_high, got.strength_high);
					fails++;
				end
				if (got.strength_total !== want.strength_total) begin
					$error("strength_total exp %0d got %0d", want.strength_total,
						got.strength_total);
					fails++;
				end
				if (got.sequence_low !== want.sequence_low) begin
					$error("sequence_low exp %0d got %0d", want.sequence_low, got.sequence_low);
					fails++;
				end
				if (got.sequence_high !== want.sequence_high) begin
					$error("sequence_high exp %0d got %0d", want.sequence_high, got.sequence_high);
					fails++;
				end
				if (got.advance_ready !== want.advance_ready) begin
					$error("advance_ready exp %0d got %0d", want.advance_ready, got.advance_ready);
					fails++;
				end
				if (got.battery_low !== want.battery_low) begin
					$error("battery_low exp %0d got %0d", want.battery_low, got.battery_low);
					fails++;
				end
				if (got.device_id !== want.device_id) begin
					$error("device_id exp %h got %h", want.device_id, got.device_id);
					fails++;
				end
			end
		end
		if (stall == 0) begin
			stall = $urandom_range(30);
			m_tready <= ($urandom_range(3) != 0);
		end else begin
			stall--;
			if (stall % 3 == 0) m_tready <= ($urandom_range(2) != 0);
		end
	end

	initial begin
		want_chan = 8'd0;
		margin = 32'd9000;
		low_start = 32'd10000;
		prev_seq = 32'd0;
		prev_dev = 48'd0;
		new_packet();
		clear_stats();
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed
		pending.push_back(item(rlts_pkg::OP_END, 8'hFF, 7'd0));
		send_packet(15, 8'd0, 32'd1, 48'd0, 8'd0, 1'b1, 7'd0);
		send_packet(16, 8'd0, 32'd9001, 48'hFFFFFFFFFFFF, 8'h80, 1'b1, 7'd127);
		send_packet(16, 8'd0, 32'd0, 48'h0, 8'hFF, 1'b1, 7'd0);
		send_packet(20, 8'd7, 32'd5, 48'h1, 8'h85, 1'b1, 7'd60);
		send_packet(16, 8'd0, 32'd5, 48'h2, 8'h85, 1'b0, 7'd60);
		send_packet(40, 8'd0, 32'hFFFFFFFF, 48'h123456789ABC, 8'h7F, 1'b1, 7'd1);
		pending.push_back(item(rlts_pkg::OP_NONE, 8'hFF, 7'h7F));
		pending.push_back(item(rlts_pkg::OP_CLEAR, 8'hAA, 7'h55));
		wait_idle();
		write_reg(rlts_pkg::REG_CHANNEL, 32'hFF);
		write_reg(rlts_pkg::REG_MARGIN, 32'hFFFFFFFF);
		write_reg(rlts_pkg::REG_SEQLOW, 32'hFFFFFFFF);
		pending.push_back(item(rlts_pkg::OP_CLEAR, 8'd0, 7'd0));
		send_packet(16, 8'hFF, 32'hFFFFFFFF, 48'h5, 8'h81, 1'b1, 7'd9);
		send_packet(16, 8'hFF, 32'd3, 48'h6, 8'h00, 1'b1, 7'd127);
		wait_idle();
		write_reg(rlts_pkg::REG_MARGIN, 32'd0);
		write_reg(rlts_pkg::REG_SEQLOW, 32'd0);
		pending.push_back(item(rlts_pkg::OP_CLEAR, 8'd0, 7'd0));
		send_packet(16, 8'hFF, 32'd1, 48'h7, 8'h80, 1'b1, 7'd3);
		wait_idle();

		// random phases
		for (int ph = 0; ph < 4; ph++) begin
			write_reg(rlts_pkg::REG_CHANNEL, $urandom_range(3) == 0 ? 32'd0 : $urandom);
			write_reg(rlts_pkg::REG_MARGIN,
				$urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
			write_reg(rlts_pkg::REG_SEQLOW,
				$urandom_range(3) == 0 ? $urandom : $urandom_range(20000));
			last_seq = $urandom_range(12000);
			for (int n = 0; n < 4; n++) begin
				case ($urandom_range(19))
					0: pending.push_back(item(rlts_pkg::OP_CLEAR, 8'($urandom), 7'($urandom)));
					1: pending.push_back(item(rlts_pkg::OP_NONE, 8'($urandom), 7'($urandom)));
					2: pending.push_back(item(rlts_pkg::OP_BYTE, 8'($urandom), 7'($urandom)));
					default: random_packet();
				endcase
			end
			wait_idle();
		end

		if (fails == 0 && stats_due.size() == 0)
			$display("radio_link_test_statistics: match");
		else
			$display("radio_link_test_statistics: mismatch");
		$finish;
	end
endmodule

>>> radio_link_test_statistics.f
src/rlts_pkg.sv
src/rlts_front.sv
src/rlts_fifo.sv
src/rlts_back.sv
src/radio_link_test_statistics.sv
bench/tb_top.sv
